[hdl/dss_pkg.sv]
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the descending shell sort engine.
// ----------------------------------------------------------------------------
package dss_pkg;

	// default number of pairs held per page
	localparam int CAPACITY_DEF = 64;

	// request type codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_END  = 1'b1;

	// gap sequence: start while GAP_MUL*g+GAP_ADD < count, grow by g*GAP_RATIO+1
	localparam int GAP_MUL   = 9;
	localparam int GAP_ADD   = 4;
	localparam int GAP_RATIO = 3;

	// floor(x/3) as (x*43)>>7, exact for x below 126
	localparam int DIV3_MUL   = 43;
	localparam int DIV3_SHIFT = 7;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] sort_key;
		logic signed [31:0] payload_word;
	} dss_in_t;

	typedef struct packed {
		logic signed [31:0] out_key;
		logic signed [31:0] out_payload;
		logic               pair_valid;
		logic               overflowed;
		logic               last_of_page;
	} dss_out_t;

	// one stored entry
	typedef struct packed {
		logic signed [31:0] key;
		logic signed [31:0] payload;
	} dss_pair_t;

	// controller to datapath strobes
	typedef struct packed {
		logic load;
		logic sort_start;
		logic gap_grow;
		logic pass_start;
		logic gap_shrink;
		logic rd_i;
		logic rd_j;
		logic shift;
		logic place;
		logic emit_rd;
		logic emit_ld;
		logic emit_empty;
		logic emit_next;
		logic page_clear;
	} dss_cmd_t;

	// datapath to controller flags
	typedef struct packed {
		logic gap_grow_ok;
		logic i_lt_n;
		logic gap_one;
		logic key_less;
		logic j_ge_gap;
		logic count_zero;
		logic out_last;
	} dss_stat_t;

endpackage

[hdl/dss_ram.sv]
// ----------------------------------------------------------------------------
// dss_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dss_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/dss_ctrl.sv]
// ----------------------------------------------------------------------------
// dss_ctrl
// Sequencer for load, gap search, gapped insertion passes and emission.
// ----------------------------------------------------------------------------
module dss_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_type,
	output logic               req_stall,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	input  dss_pkg::dss_stat_t stat,
	output dss_pkg::dss_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_GAP     = 4'd1;
	localparam logic [3:0] S_PASS    = 4'd2;
	localparam logic [3:0] S_RD_J    = 4'd3;
	localparam logic [3:0] S_CMP     = 4'd4;
	localparam logic [3:0] S_PLACE   = 4'd5;
	localparam logic [3:0] S_EMIT    = 4'd6;
	localparam logic [3:0] S_EMIT_LD = 4'd7;
	localparam logic [3:0] S_OUT     = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       req_xact;
	logic       rsp_xact;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_OUT);
	assign req_xact  = req_valid && !req_stall;
	assign rsp_xact  = rsp_valid && !rsp_stall;

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_xact) begin
					if (req_type == dss_pkg::REQ_END) begin
						cmd.sort_start = 1'b1;
						state_d        = S_GAP;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_GAP: begin
				if (stat.gap_grow_ok) begin
					cmd.gap_grow = 1'b1;
				end else begin
					cmd.pass_start = 1'b1;
					state_d        = S_PASS;
				end
			end
			S_PASS: begin
				if (stat.i_lt_n) begin
					cmd.rd_i = 1'b1;
					state_d  = S_RD_J;
				end else if (stat.gap_one) begin
					state_d = S_EMIT;
				end else begin
					cmd.gap_shrink = 1'b1;
				end
			end
			S_RD_J: begin
				cmd.rd_j = 1'b1;
				state_d  = S_CMP;
			end
			S_CMP: begin
				if (stat.key_less) begin
					cmd.shift = 1'b1;
					if (!stat.j_ge_gap) begin
						state_d = S_PLACE;
					end
				end else begin
					cmd.place = 1'b1;
					state_d   = S_PASS;
				end
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				state_d   = S_PASS;
			end
			S_EMIT: begin
				if (stat.count_zero) begin
					cmd.emit_empty = 1'b1;
					state_d        = S_OUT;
				end else begin
					cmd.emit_rd = 1'b1;
					state_d     = S_EMIT_LD;
				end
			end
			S_EMIT_LD: begin
				cmd.emit_ld = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (rsp_xact) begin
					if (stat.out_last) begin
						cmd.page_clear = 1'b1;
						state_d        = S_IDLE;
					end else begin
						cmd.emit_next = 1'b1;
						state_d       = S_EMIT;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a finished page always returns to idle with no strobe left over
	a_clear_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.page_clear |=> (state_q == S_IDLE))
		else $error("page clear did not return to idle");

	// a shift only happens while comparing
	a_shift_in_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> (state_q == S_CMP) && stat.key_less)
		else $error("shift outside compare");

	// a stalled result stays offered in the output state
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> rsp_valid && (state_q == S_OUT))
		else $error("pending result dropped");

endmodule

[hdl/dss_dp.sv]
// ----------------------------------------------------------------------------
// dss_dp
// Pair store, sort indexes, key compare and output register.
// ----------------------------------------------------------------------------
module dss_dp #(
	parameter int CAPACITY = dss_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dss_pkg::dss_in_t   req_data,
	input  dss_pkg::dss_cmd_t  cmd,
	output dss_pkg::dss_stat_t stat,
	output dss_pkg::dss_out_t  rsp_data
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int PW = $bits(dss_pkg::dss_pair_t);

	logic [CW-1:0]      count_q;
	logic               ovf_q;
	logic [CW-1:0]      gap_q;
	logic [CW-1:0]      i_q;
	logic [CW-1:0]      j_q;
	logic [CW-1:0]      k_q;
	logic [CW-1:0]      r_q;
	dss_pkg::dss_pair_t hold_q;
	dss_pkg::dss_out_t  out_q;

	logic               full;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [PW-1:0]      wr_data;
	logic [AW-1:0]      rd_addr;
	logic [PW-1:0]      rd_raw;
	dss_pkg::dss_pair_t rd_pair;
	dss_pkg::dss_pair_t in_pair;
	logic [CW-1:0]      i_minus_gap;
	logic [CW-1:0]      j_minus_gap;
	logic [CW+3:0]      gap_test;
	logic [CW+1:0]      gap_up;
	logic [CW+5:0]      gap_x43;
	logic [CW-1:0]      gap_div3;

	assign full    = (count_q == CW'(CAPACITY));
	assign rd_pair = dss_pkg::dss_pair_t'(rd_raw);
	assign in_pair = '{key: req_data.sort_key, payload: req_data.payload_word};

	// gap arithmetic
	assign gap_test = (CW+4)'(gap_q) * (CW+4)'(dss_pkg::GAP_MUL) + (CW+4)'(dss_pkg::GAP_ADD);
	assign gap_up   = (CW+2)'(gap_q) * (CW+2)'(dss_pkg::GAP_RATIO) + (CW+2)'(1);
	assign gap_x43  = (CW+6)'(gap_q) * (CW+6)'(dss_pkg::DIV3_MUL);
	assign gap_div3 = CW'(gap_x43 >> dss_pkg::DIV3_SHIFT);

	assign i_minus_gap = i_q - gap_q;
	assign j_minus_gap = j_q - gap_q;

	// store write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		if (cmd.load) begin
			wr_en   = !full;
			wr_addr = count_q[AW-1:0];
			wr_data = in_pair;
		end else if (cmd.shift) begin
			wr_en   = 1'b1;
			wr_addr = k_q[AW-1:0];
			wr_data = rd_pair;
		end else if (cmd.place) begin
			wr_en   = 1'b1;
			wr_addr = k_q[AW-1:0];
			wr_data = hold_q;
		end
	end

	// store read address
	always_comb begin
		rd_addr = '0;
		if (cmd.rd_i) begin
			rd_addr = i_q[AW-1:0];
		end else if (cmd.rd_j) begin
			rd_addr = i_minus_gap[AW-1:0];
		end else if (cmd.shift) begin
			rd_addr = j_minus_gap[AW-1:0];
		end else if (cmd.emit_rd) begin
			rd_addr = r_q[AW-1:0];
		end
	end

	dss_ram #(
		.WIDTH(PW),
		.DEPTH(CAPACITY)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	// page count, overflow flag and emit read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			r_q     <= '0;
		end else begin
			if (cmd.page_clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				r_q     <= '0;
			end else begin
				if (cmd.load) begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						count_q <= count_q + CW'(1);
					end
				end
				if (cmd.emit_next) begin
					r_q <= r_q + CW'(1);
				end
			end
		end
	end

	// gap and insertion indexes
	always_ff @(posedge clk) begin
		if (cmd.sort_start) begin
			gap_q <= CW'(1);
		end else if (cmd.gap_grow) begin
			gap_q <= CW'(gap_up);
		end else if (cmd.gap_shrink) begin
			gap_q <= gap_div3;
		end
		if (cmd.pass_start) begin
			i_q <= gap_q;
		end else if (cmd.gap_shrink) begin
			i_q <= gap_div3;
		end else if (cmd.place) begin
			i_q <= i_q + CW'(1);
		end
		if (cmd.rd_j) begin
			hold_q <= rd_pair;
			j_q    <= i_minus_gap;
			k_q    <= i_q;
		end else if (cmd.shift) begin
			k_q <= j_q;
			j_q <= j_minus_gap;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit_empty) begin
			out_q.out_key      <= '0;
			out_q.out_payload  <= '0;
			out_q.pair_valid   <= 1'b0;
			out_q.overflowed   <= ovf_q;
			out_q.last_of_page <= 1'b1;
		end else if (cmd.emit_ld) begin
			out_q.out_key      <= rd_pair.key;
			out_q.out_payload  <= rd_pair.payload;
			out_q.pair_valid   <= 1'b1;
			out_q.overflowed   <= ovf_q;
			out_q.last_of_page <= (r_q + CW'(1) == count_q);
		end
	end

	assign rsp_data = out_q;

	// status back to the sequencer
	assign stat.gap_grow_ok = (gap_test < (CW+4)'(count_q));
	assign stat.i_lt_n      = (i_q < count_q);
	assign stat.gap_one     = (gap_q == CW'(1));
	assign stat.key_less    = (rd_pair.key < hold_q.key);
	assign stat.j_ge_gap    = (j_q >= gap_q);
	assign stat.count_zero  = (count_q == '0);
	assign stat.out_last    = out_q.last_of_page;

	// fill count stays within the store
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	// sort writes only touch entries of the current page
	a_sort_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift || cmd.place) |-> (k_q < count_q))
		else $error("sort write outside held entries");

	// a shift always moves an entry toward higher index
	a_shift_dir: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> (j_q < k_q))
		else $error("shift in wrong direction");

endmodule

[hdl/descending_shell_sort_key_payload_top.sv]
// ----------------------------------------------------------------------------
// descending_shell_sort_key_payload_top
// Load-then-sort engine emitting key and payload pairs in descending key order.
// ----------------------------------------------------------------------------
// A load transaction stores one pair; loads past CAPACITY are dropped and set
// the overflow flag. An end transaction sorts the held pairs with a Shell sort
// (gaps 1, 4, 13, ...) and then returns them one result per pair, or one empty
// result when nothing is held, and clears the page. The store is a RAM with a
// single registered read port, so the sort first searches for the start gap,
// then for each gap runs insertion steps that read, compare and shift entries
// before placing the held pair; each non-empty result is read from the store
// and loaded into the output register before it is offered. No new request is
// taken until the last result of the page has been delivered.
// ----------------------------------------------------------------------------
module descending_shell_sort_key_payload_top #(
	parameter int CAPACITY = dss_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  dss_pkg::dss_in_t  req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output dss_pkg::dss_out_t rsp_data
);

	dss_pkg::dss_cmd_t  cmd;
	dss_pkg::dss_stat_t stat;

	// sequencer
	dss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_type (req_data.req_type),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// store and compare datapath
	dss_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_data(req_data),
		.cmd     (cmd),
		.stat    (stat),
		.rsp_data(rsp_data)
	);

endmodule
